// ===== hw/rtl/iib_pkg.sv =====
`default_nettype none
package iib_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SUM_W     = 30;
  localparam int unsigned RUN_W     = 19;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned LIM_W     = 14;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned MAX_HEIGHT   = 2048;

  localparam int unsigned RESET_WIDTH    = 640;
  localparam int unsigned RESET_HEIGHT   = 480;
  localparam int unsigned RESET_CHANNELS = 1;

  localparam logic [1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_CHANNELS_IN_USE = 2'd2;

  // shared pipeline control, one copy for all lanes
  typedef struct packed {
    logic accept;
    logic row_end;
    logic first_row;
    logic s1_move;
  } iib_ctrl_t;

  function automatic logic [LIM_W-1:0] clamp_lim(input logic [LIM_W-1:0] v,
                                                 input logic [LIM_W-1:0] hi);
    logic [LIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/integral_image_builder_core.sv =====
// Integral image builder: one multi-channel pixel per input word, raster order.
// Each result word carries the summed-area value of every channel up to and
// including that pixel, with frame_done set on the last pixel of the frame.
// Channels: in_* (valid/ready) for pixels, out_* (valid/ready) for results,
// cfg_* for frame_width (0), frame_height (1) and channels_in_use (2); write
// the registers only while no pixel is in flight.
// An accepted pixel passes the read stage, then the output register.
// Throughput: one pixel per cycle unless the output stalls, set by one
// line-buffer read and write per lane per cycle; four lanes each own a line
// buffer of MAX_WIDTH entries. The stage after the line-buffer read forwards
// a column just written, so a one-pixel-wide frame still runs at full rate.
// Reset clears the row/column counters and running sums and loads the
// register defaults (640 x 480, one channel); line buffers are not cleared,
// the first row of each frame never reads them.
// When out_ready is low the result is held in the output register; one more
// pixel is taken into the read stage, after which in_ready drops until the
// output drains.
`default_nettype none
module integral_image_builder_core #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [iib_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [iib_pkg::PIX_W-1:0]     in_channel_value_0,
  input  wire logic [iib_pkg::PIX_W-1:0]     in_channel_value_1,
  input  wire logic [iib_pkg::PIX_W-1:0]     in_channel_value_2,
  input  wire logic [iib_pkg::PIX_W-1:0]     in_channel_value_3,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [iib_pkg::SUM_W-1:0]     out_area_sum_0,
  output logic      [iib_pkg::SUM_W-1:0]     out_area_sum_1,
  output logic      [iib_pkg::SUM_W-1:0]     out_area_sum_2,
  output logic      [iib_pkg::SUM_W-1:0]     out_area_sum_3,
  output logic                               out_frame_done
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [iib_pkg::LIM_W-1:0] WIDTH_LIM = iib_pkg::LIM_W'(MAX_WIDTH);
  localparam logic [iib_pkg::LIM_W-1:0] HEIGHT_LIM = iib_pkg::LIM_W'(iib_pkg::MAX_HEIGHT);
  localparam logic [iib_pkg::LIM_W-1:0] CH_LIM = iib_pkg::LIM_W'(iib_pkg::MAX_CHANNELS);

  logic [iib_pkg::LIM_W-1:0] width_r;
  logic [iib_pkg::LIM_W-1:0] height_r;
  logic [iib_pkg::CH_W-1:0]  nch_r;

  logic [iib_pkg::POS_W-1:0] col_r, col_nxt;
  logic [iib_pkg::POS_W-1:0] row_r, row_nxt;
  logic [iib_pkg::LIM_W-1:0] col_inc, row_inc;
  logic                      row_end, frame_end;

  logic                      s1_valid_r;
  logic                      s1_done_r;
  logic                      out_valid_r;
  logic                      out_done_r;
  logic [iib_pkg::SUM_W-1:0] area_r [iib_pkg::NUM_LANES];
  logic [iib_pkg::SUM_W-1:0] lane_sum [iib_pkg::NUM_LANES];
  logic [iib_pkg::PIX_W-1:0] pix [iib_pkg::NUM_LANES];

  iib_pkg::iib_ctrl_t ctl;
  logic               accept;
  logic               s1_move;

  // configuration, kept already clamped to the legal range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= iib_pkg::clamp_lim(iib_pkg::LIM_W'(iib_pkg::RESET_WIDTH), WIDTH_LIM);
      height_r <= iib_pkg::clamp_lim(iib_pkg::LIM_W'(iib_pkg::RESET_HEIGHT), HEIGHT_LIM);
      nch_r    <= iib_pkg::CH_W'(iib_pkg::RESET_CHANNELS);
    end else if (cfg_we) begin
      case (cfg_index)
        iib_pkg::REG_FRAME_WIDTH: begin
          width_r <= iib_pkg::clamp_lim(iib_pkg::LIM_W'(cfg_wdata), WIDTH_LIM);
        end
        iib_pkg::REG_FRAME_HEIGHT: begin
          height_r <= iib_pkg::clamp_lim(iib_pkg::LIM_W'(cfg_wdata), HEIGHT_LIM);
        end
        iib_pkg::REG_CHANNELS_IN_USE: begin
          nch_r <= iib_pkg::CH_W'(iib_pkg::clamp_lim(
                     iib_pkg::LIM_W'(cfg_wdata[iib_pkg::CH_W-1:0]), CH_LIM));
        end
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign s1_move  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_move;
  assign accept   = in_valid & in_ready;

  // raster counters
  assign col_inc   = iib_pkg::LIM_W'(col_r) + iib_pkg::LIM_W'(1);
  assign row_inc   = iib_pkg::LIM_W'(row_r) + iib_pkg::LIM_W'(1);
  assign row_end   = (col_inc >= width_r);
  assign frame_end = row_end & (row_inc >= height_r);

  always_comb begin
    col_nxt = row_end ? '0 : col_inc[iib_pkg::POS_W-1:0];
    row_nxt = row_r;
    if (row_end) begin
      row_nxt = frame_end ? '0 : row_inc[iib_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_done_r <= frame_end;
    end
  end

  assign ctl.accept    = accept;
  assign ctl.row_end   = row_end;
  assign ctl.first_row = (row_r == '0);
  assign ctl.s1_move   = s1_move;

  assign pix[0] = in_channel_value_0;
  assign pix[1] = in_channel_value_1;
  assign pix[2] = in_channel_value_2;
  assign pix[3] = in_channel_value_3;

  for (genvar g = 0; g < iib_pkg::NUM_LANES; g++) begin : g_lane
    iib_lane #(
      .MAX_WIDTH(MAX_WIDTH)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .lane_en(iib_pkg::CH_W'(g) < nch_r),
      .pix    (pix[g]),
      .addr   (AW'(col_r)),
      .total  (lane_sum[g])
    );
  end

  // merge lane totals into the output word
  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int i = 0; i < iib_pkg::NUM_LANES; i++) begin
        area_r[i] <= lane_sum[i];
      end
      out_done_r <= s1_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_area_sum_0 = area_r[0];
  assign out_area_sum_1 = area_r[1];
  assign out_area_sum_2 = area_r[2];
  assign out_area_sum_3 = area_r[3];
  assign out_frame_done = out_done_r;

endmodule
`default_nettype wire

// ===== hw/rtl/iib_ram.sv =====
`default_nettype none
module iib_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/iib_lane.sv =====
`default_nettype none
module iib_lane #(
  parameter int unsigned MAX_WIDTH = 2048,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire iib_pkg::iib_ctrl_t           ctl,
  input  wire logic                         lane_en,
  input  wire logic [iib_pkg::PIX_W-1:0]    pix,
  input  wire logic [AW-1:0]                addr,
  output logic      [iib_pkg::SUM_W-1:0]    total
);

  logic [iib_pkg::RUN_W-1:0] run_r;
  logic [iib_pkg::RUN_W-1:0] run_sum;
  logic [iib_pkg::RUN_W-1:0] s1_run_r;
  logic                      s1_en_r;
  logic                      s1_first_r;
  logic [AW-1:0]             s1_addr_r;
  logic                      fwd_r;
  logic [iib_pkg::SUM_W-1:0] fwd_data_r;
  logic [iib_pkg::SUM_W-1:0] rd_data;
  logic [iib_pkg::SUM_W-1:0] above;
  logic                      wr_en;

  assign run_sum = run_r + iib_pkg::RUN_W'(pix);

  // row above: zero on the first row, bypass when the previous word wrote this column
  always_comb begin
    if (s1_first_r) begin
      above = '0;
    end else if (fwd_r) begin
      above = fwd_data_r;
    end else begin
      above = rd_data;
    end
  end

  assign total = s1_en_r ? (above + iib_pkg::SUM_W'(s1_run_r)) : '0;
  assign wr_en = ctl.s1_move & s1_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      s1_en_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else if (ctl.accept) begin
      run_r   <= (ctl.row_end || !lane_en) ? '0 : run_sum;
      s1_en_r <= lane_en;
      fwd_r   <= wr_en && (s1_addr_r == addr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_run_r   <= lane_en ? run_sum : '0;
      s1_first_r <= ctl.first_row;
      s1_addr_r  <= addr;
      fwd_data_r <= total;
    end
  end

  iib_ram #(
    .WIDTH(iib_pkg::SUM_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_addr_r),
    .wdata(total),
    .re   (ctl.accept),
    .raddr(addr),
    .rdata(rd_data)
  );

endmodule
`default_nettype wire
